// ----- rtl/rth_pkg.sv -----
package rth_pkg;

  // Hue scale: 1/64 degree per unit.
  localparam logic [14:0] HUE_FULL  = 15'd23040;
  localparam logic [14:0] HUE_OFF_G = 15'd7680;
  localparam logic [14:0] HUE_OFF_B = 15'd15360;

  // Quotient widths of the two long divisions.
  localparam int HUE_QW = 12;  // 3840*x/d stays at or below 3840
  localparam int SAT_QW = 8;   // 255*d/max stays at or below 255

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Payload of one divider stage.
  typedef struct packed {
    logic [19:0]       hrem;  // hue remainder, starts as 3840*|p-q|
    logic [7:0]        hdiv;  // max-min, forced to 1 for a grey pixel
    logic [HUE_QW-1:0] hq;
    logic [15:0]       srem;  // saturation remainder, starts as 255*(max-min)
    logic [7:0]        sdiv;  // max, forced to 1 for a black pixel
    logic [SAT_QW-1:0] sq;
    sector_t           sec;
    logic              neg;   // channel difference is negative
    logic [7:0]        mx;
  } pipe_t;

endpackage

// ----- rtl/rgb_to_hsv.sv -----
// Channel   Ports                                          Direction
// --------  ---------------------------------------------  ---------
// request   in_valid, in_stall, in_red/green/blue          into block
// result    out_valid, out_stall, out_hue/saturation/value out of block
//
// One pixel enters per clock while in_stall is low; each result passes
// through one front stage, twelve divider steps and one output stage.
// The twelve steps of the long division set the depth: one quotient bit
// per stage for hue, saturation sharing the last eight of them.
// Reset (rst_n low, synchronous) empties every stage.
// A stall on the result side holds only the full stages; empty stages
// further up keep filling, and in_stall rises once the whole pipe is full.
module rgb_to_hsv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_hue,
  output logic [7:0]  out_saturation,
  output logic [7:0]  out_value
);
  import rth_pkg::*;

  localparam int NSTEP = HUE_QW;     // divider stages
  localparam int NSTG  = NSTEP + 2;  // front + divider + output
  localparam int OUTS  = NSTG - 1;   // index of the output stage

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;
  pipe_t           pipe_r [NSTEP+1];
  pipe_t           pipe_nxt [NSTEP+1];

  logic [14:0] out_hue_r;
  logic [7:0]  out_saturation_r;
  logic [7:0]  out_value_r;
  logic [14:0] hue_nxt;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    adv[OUTS] = !vld_r[OUTS] || !out_stall;
    for (int k = OUTS - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Front stage: max, min, sector and the two dividends.
  logic [7:0] fr_mx, fr_mn, fr_d, fr_p, fr_q, fr_x;
  sector_t    fr_sec;

  always_comb begin
    fr_mx = (in_red >= in_green) ? in_red : in_green;
    fr_mx = (fr_mx >= in_blue) ? fr_mx : in_blue;
    fr_mn = (in_red <= in_green) ? in_red : in_green;
    fr_mn = (fr_mn <= in_blue) ? fr_mn : in_blue;
    fr_d  = fr_mx - fr_mn;
    // Ties go to red, then green. A grey pixel lands in red with a zero term.
    priority if (fr_mx == in_red) begin
      fr_sec = SEC_RED;
      fr_p   = in_green;
      fr_q   = in_blue;
    end else if (fr_mx == in_green) begin
      fr_sec = SEC_GREEN;
      fr_p   = in_blue;
      fr_q   = in_red;
    end else begin
      fr_sec = SEC_BLUE;
      fr_p   = in_red;
      fr_q   = in_green;
    end
    fr_x = (fr_p >= fr_q) ? (fr_p - fr_q) : (fr_q - fr_p);

    pipe_nxt[0].hrem = {fr_x, 12'd0} - {4'd0, fr_x, 8'd0};  // 3840*x
    pipe_nxt[0].hdiv = (fr_d == 8'd0) ? 8'd1 : fr_d;
    pipe_nxt[0].hq   = '0;
    pipe_nxt[0].srem = {fr_d, 8'd0} - {8'd0, fr_d};          // 255*d
    pipe_nxt[0].sdiv = (fr_mx == 8'd0) ? 8'd1 : fr_mx;
    pipe_nxt[0].sq   = '0;
    pipe_nxt[0].sec  = fr_sec;
    pipe_nxt[0].neg  = (fr_p < fr_q);
    pipe_nxt[0].mx   = fr_mx;
  end

  // Divider steps: one restoring subtract per stage, MSB first.
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    localparam int B = NSTEP - k;
    logic [19:0] hsh;
    assign hsh = 20'(pipe_r[k-1].hdiv) << B;

    if (B < SAT_QW) begin : g_sat
      logic [15:0] ssh;
      assign ssh = 16'(pipe_r[k-1].sdiv) << B;
      always_comb begin
        pipe_nxt[k] = pipe_r[k-1];
        if (pipe_r[k-1].hrem >= hsh) begin
          pipe_nxt[k].hrem  = pipe_r[k-1].hrem - hsh;
          pipe_nxt[k].hq[B] = 1'b1;
        end
        if (pipe_r[k-1].srem >= ssh) begin
          pipe_nxt[k].srem  = pipe_r[k-1].srem - ssh;
          pipe_nxt[k].sq[B] = 1'b1;
        end
      end
    end else begin : g_hue_only
      always_comb begin
        pipe_nxt[k] = pipe_r[k-1];
        if (pipe_r[k-1].hrem >= hsh) begin
          pipe_nxt[k].hrem  = pipe_r[k-1].hrem - hsh;
          pipe_nxt[k].hq[B] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      pipe_r[0] <= pipe_nxt[0];
    end
    for (int k = 1; k <= NSTEP; k++) begin
      if (adv[k] && vld_r[k-1]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // Output stage: add the sector offset and wrap below a full turn.
  logic [14:0] fin_q;
  assign fin_q = 15'(pipe_r[NSTEP].hq);

  always_comb begin
    unique case (pipe_r[NSTEP].sec)
      SEC_RED: begin
        if (!pipe_r[NSTEP].neg || fin_q == 15'd0) begin
          hue_nxt = fin_q;
        end else begin
          hue_nxt = HUE_FULL - fin_q;
        end
      end
      SEC_GREEN: begin
        hue_nxt = pipe_r[NSTEP].neg ? (HUE_OFF_G - fin_q) : (HUE_OFF_G + fin_q);
      end
      SEC_BLUE: begin
        hue_nxt = pipe_r[NSTEP].neg ? (HUE_OFF_B - fin_q) : (HUE_OFF_B + fin_q);
      end
      default: begin
        hue_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[OUTS] && vld_r[OUTS-1]) begin
      out_hue_r        <= hue_nxt;
      out_saturation_r <= pipe_r[NSTEP].sq;
      out_value_r      <= pipe_r[NSTEP].mx;
    end
  end

  assign out_valid      = vld_r[OUTS];
  assign out_hue        = out_hue_r;
  assign out_saturation = out_saturation_r;
  assign out_value      = out_value_r;

`ifndef SYNTH
  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_FULL)
    else $error("hue out of range");

  a_black : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value == 8'd0) |-> (out_saturation == 8'd0 && out_hue == 15'd0))
    else $error("black pixel with nonzero hue or saturation");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("request stalled with an empty stage");

  a_take : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted request lost at front stage");
`endif

endmodule

// ----- bench/hsv_checker.sv -----
`timescale 1ns / 1ps

module hsv_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [14:0] out_hue,
  input  logic [7:0]  out_saturation,
  input  logic [7:0]  out_value,
  output int          errors,
  output int          pending,
  output int          checked
);
  import rth_pkg::*;

  localparam int HUE_SIXTY = 3840;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_t;

  hsv_t hsv_expected_q[$];
  int   err_cnt = 0;
  int   pend_cnt = 0;
  int   chk_cnt = 0;

  assign errors  = err_cnt;
  assign pending = pend_cnt;
  assign checked = chk_cnt;

  function automatic hsv_t predict_hsv(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    hsv_t    res;
    sector_t sec;
    int      mx, mn, d, p, q, off, mag, hue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    d  = mx - mn;
    // Red wins ties over green, green over blue.
    if (r >= g && r >= b) sec = SEC_RED;
    else if (g >= b)      sec = SEC_GREEN;
    else                  sec = SEC_BLUE;
    case (sec)
      SEC_GREEN: begin off = int'(HUE_OFF_G); p = b; q = r; end
      SEC_BLUE:  begin off = int'(HUE_OFF_B); p = r; q = g; end
      default:   begin off = 0;               p = g; q = b; end
    endcase
    if (d == 0) begin
      hue = 0;
    end else begin
      mag = (HUE_SIXTY * ((p >= q) ? p - q : q - p)) / d;
      hue = (int'(HUE_FULL) + off + ((p >= q) ? mag : -mag)) % int'(HUE_FULL);
    end
    res.hue = 15'(hue);
    res.sat = (mx == 0) ? 8'd0 : 8'((255 * d) / mx);
    res.val = 8'(mx);
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    if (!rst_n) begin
      hsv_expected_q.delete();
    end else begin
      if (in_valid && !in_stall)
        hsv_expected_q.push_back(predict_hsv(in_red, in_green, in_blue));
      if (out_valid && !out_stall) begin
        chk_cnt++;
        if (hsv_expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $time,
                     out_hue, out_saturation, out_value);
        end else begin
          want = hsv_expected_q.pop_front();
          if (out_hue !== want.hue || out_saturation !== want.sat ||
              out_value !== want.val) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: mismatch hue %0d/%0d sat %0d/%0d val %0d/%0d (exp/act)",
                       $time, want.hue, out_hue, want.sat, out_saturation,
                       want.val, out_value);
          end
        end
      end
    end
    pend_cnt = hsv_expected_q.size();
  end

endmodule

// ----- bench/tb_rgb_to_hsv.sv -----
`timescale 1ns / 1ps

module tb_rgb_to_hsv;

  localparam int RANDOM_PIXELS = 550;
  // Last stretch of the random part runs with no idling on either side.
  localparam int QUIET_TAIL = 80;
  // Pipe depth is 14 stages; give a little margin after the drain.
  localparam int DRAIN_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = 8'd0;
  logic [7:0]  in_green = 8'd0;
  logic [7:0]  in_blue = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_hue;
  logic [7:0]  out_saturation;
  logic [7:0]  out_value;

  int errors;
  int pending;
  int checked;
  int pixels_sent = 0;
  bit quiet = 1'b0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_hsv DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value)
  );

  hsv_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value),
    .errors         (errors),
    .pending        (pending),
    .checked        (checked)
  );

  // Result-side backpressure: raise out_stall in random bursts.
  // Compute the next level first so out_stall sees a single update per edge.
  int stall_left = 0;
  always @(posedge clk) begin
    logic stall_next;
    if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (!quiet && rst_n && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
    end
    out_stall <= stall_next;
  end

  // Send one pixel request. Optionally idle first for a random burst,
  // then hold the payload until the block takes it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Main sequence: reset, directed corners, random pixels, drain, verdict.
  initial begin
    int         mode;
    logic [7:0] a, lo, hi;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Black and white, plus a mid and a dark grey: hue stays at zero.
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    // Primaries at full and minimal intensity.
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    // Ties for the largest channel: red beats green, green beats blue.
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd200, 8'd200, 8'd37);
    // Negative channel difference in each sector; red wraps below 360 deg.
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd10,  8'd255, 8'd0);
    send_pixel(8'd0,   8'd1,   8'd255);
    // Positive differences, and a near-grey pixel with a negative one.
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd170, 8'd85,  8'd255);
    send_pixel(8'd255, 8'd1,   8'd0);

    // Random part: uniform pixels half the time, with shaped cases mixed in.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS - QUIET_TAIL) quiet = 1'b1;
      mode = $urandom_range(0, 9);
      a  = 8'($urandom);
      lo = 8'($urandom_range(0, 254));
      hi = 8'($urandom_range(lo + 1, 255));
      case (mode)
        5: send_pixel(a, a, a);
        6: begin
          // Two channels share the maximum.
          case ($urandom_range(0, 2))
            0:       send_pixel(hi, hi, lo);
            1:       send_pixel(lo, hi, hi);
            default: send_pixel(hi, lo, hi);
          endcase
        end
        7: begin
          // Saturated colors: one channel at an extreme.
          case ($urandom_range(0, 2))
            0:       send_pixel(8'd255, a, 8'd0);
            1:       send_pixel(8'd0, 8'd255, a);
            default: send_pixel(a, 8'd0, 8'd255);
          endcase
        end
        8: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      8'($urandom_range(0, 3)));
        9: begin
          // Max minus min of one: largest hue steps.
          case ($urandom_range(0, 2))
            0:       send_pixel(hi, 8'(hi - 1), 8'(hi - $urandom_range(0, 1)));
            1:       send_pixel(8'(hi - $urandom_range(0, 1)), hi, 8'(hi - 1));
            default: send_pixel(8'(hi - 1), 8'(hi - $urandom_range(0, 1)), hi);
          endcase
        end
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then let the pipe settle.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d pixels sent (directed corners, ties, wraps, random),", pixels_sent);
    $display("summary: %0d results compared under random idle and stall bursts", checked);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: the run should finish well inside this.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
